### src/rps_pkg.sv
// Shared types and constants for the run-length palette sprite decoder.
// Used by every module under src; depends on nothing.
package rps_pkg;

   localparam int PALETTE_ENTRIES = 256;

   // Depth of the command queue between parser and pixel back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Request commands
   localparam logic [1:0] CMD_STREAM  = 2'd0;
   localparam logic [1:0] CMD_PAL_WR  = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Register indexes on the csr port
   localparam logic CSR_TRANSPARENT = 1'b0;
   localparam logic CSR_SEMI        = 1'b1;

   localparam logic [7:0] TRANSPARENT_RESET = 8'd0;
   localparam logic [7:0] SEMI_RESET        = 8'd1;

   localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
   localparam logic [7:0] ALPHA_SEMI   = 8'd127;
   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   typedef enum logic [4:0] {
      MODE_CODE   = 5'b00001,
      MODE_TCOUNT = 5'b00010,
      MODE_SCOUNT = 5'b00100,
      MODE_SIDX   = 5'b01000,
      MODE_OIDX   = 5'b10000
   } parse_mode_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'b00,
      OP_PIXEL = 2'b01,
      OP_CLEAR = 2'b10
   } op_type;

   // One queued operation for the back end
   typedef struct packed {
      op_type      op;
      logic [7:0]  addr;
      logic [15:0] color;
      logic [7:0]  alpha;
      logic [7:0]  repeat_cnt;
   } q_entry_type;

endpackage

### src/rps_front.sv
// Stream parser: holds the code registers and parse state, turns each
// accepted request into at most one queued operation. Depends on rps_pkg.
module rps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [7:0]          csr_data,
   input  logic                accept,
   input  logic [1:0]          cmd,
   input  logic [7:0]          data_byte,
   input  logic [7:0]          palette_slot,
   input  logic [15:0]         palette_color,
   output logic                push,
   output rps_pkg::q_entry_type push_entry
);

   logic [7:0]              transparent_code_ff;
   logic [7:0]              semi_code_ff;
   rps_pkg::parse_mode_type mode_ff, mode_in;
   logic [7:0]              run_left_ff, run_left_in;
   logic                    push_in;
   rps_pkg::q_entry_type    entry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         transparent_code_ff <= rps_pkg::TRANSPARENT_RESET;
         semi_code_ff        <= rps_pkg::SEMI_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rps_pkg::CSR_TRANSPARENT: transparent_code_ff <= csr_data;
            rps_pkg::CSR_SEMI:        semi_code_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in             = mode_ff;
      run_left_in         = run_left_ff;
      push_in             = 1'b0;
      entry_in.op         = rps_pkg::OP_PIXEL;
      entry_in.addr       = data_byte;
      entry_in.color      = palette_color;
      entry_in.alpha      = rps_pkg::ALPHA_OPAQUE;
      entry_in.repeat_cnt = 8'd1;
      case (cmd)
         rps_pkg::CMD_PAL_WR: begin
            push_in       = 1'b1;
            entry_in.op   = rps_pkg::OP_WRITE;
            entry_in.addr = palette_slot;
         end
         rps_pkg::CMD_RESTART: begin
            mode_in     = rps_pkg::MODE_CODE;
            run_left_in = 8'd0;
         end
         rps_pkg::CMD_STREAM: begin
            case (mode_ff)
               rps_pkg::MODE_TCOUNT: begin
                  mode_in = rps_pkg::MODE_CODE;
                  if (data_byte != 8'd0) begin
                     push_in             = 1'b1;
                     entry_in.op         = rps_pkg::OP_CLEAR;
                     entry_in.alpha      = rps_pkg::ALPHA_CLEAR;
                     entry_in.repeat_cnt = data_byte;
                  end
               end
               rps_pkg::MODE_SCOUNT: begin
                  run_left_in = data_byte;
                  mode_in = (data_byte == 8'd0) ? rps_pkg::MODE_CODE : rps_pkg::MODE_SIDX;
               end
               rps_pkg::MODE_SIDX, rps_pkg::MODE_OIDX: begin
                  push_in        = 1'b1;
                  entry_in.alpha = (mode_ff == rps_pkg::MODE_SIDX) ?
                                   rps_pkg::ALPHA_SEMI : rps_pkg::ALPHA_OPAQUE;
                  run_left_in    = run_left_ff - 8'd1;
                  if (run_left_ff == 8'd1) begin
                     mode_in = rps_pkg::MODE_CODE;
                  end
               end
               default: begin
                  if (data_byte == transparent_code_ff) begin
                     mode_in = rps_pkg::MODE_TCOUNT;
                  end else if (data_byte == semi_code_ff) begin
                     mode_in = rps_pkg::MODE_SCOUNT;
                  end else begin
                     run_left_in = data_byte;
                     mode_in = (data_byte == 8'd0) ? rps_pkg::MODE_CODE :
                                                     rps_pkg::MODE_OIDX;
                  end
               end
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= rps_pkg::MODE_CODE;
         run_left_ff <= 8'd0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         run_left_ff <= run_left_in;
      end
   end

   assign push       = accept && push_in;
   assign push_entry = entry_in;

`ifndef ASSERT_OFF
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == rps_pkg::MODE_SIDX || mode_ff == rps_pkg::MODE_OIDX) |-> run_left_ff != 8'd0)
      else $error("index run active with nothing left");
`endif

endmodule

### src/rps_queue.sv
// Short command queue between parser and back end.
// Depends on rps_pkg for the entry type and depth.
module rps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rps_pkg::q_entry_type push_entry,
   output logic                 full,
   output logic                 head_valid,
   output rps_pkg::q_entry_type head_entry,
   input  logic                 pop
);

   rps_pkg::q_entry_type             slots_ff [rps_pkg::QUEUE_DEPTH];
   logic [rps_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [rps_pkg::QCNT_W-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   assign full       = (count_ff == rps_pkg::QCNT_W'(rps_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");
`endif

endmodule

### src/rps_back.sv
// Back end: palette memory, registered lookup and output register.
// Depends on rps_pkg for the queue entry type and alpha constants.
module rps_back #(
   parameter int PALETTE_ENTRIES = rps_pkg::PALETTE_ENTRIES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  rps_pkg::q_entry_type head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_red,
   output logic [7:0]           rsp_green,
   output logic [7:0]           rsp_blue,
   output logic [7:0]           rsp_alpha,
   output logic [7:0]           rsp_repeat_res
);

   localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [15:0] palette_mem [PALETTE_ENTRIES];
   logic [15:0] rd_data_ff;
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_hit_ff;
   logic [7:0]  s1_alpha_ff, s1_repeat_ff;
   logic        out_free, s1_free, in_range, is_write;
   logic [15:0] color;

   logic        rsp_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff, repeat_ff;

   assign in_range = ({1'b0, head_entry.addr} < 9'(PALETTE_ENTRIES));
   assign is_write = (head_entry.op == rps_pkg::OP_WRITE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head_valid && s1_free;

   always_ff @(posedge clock) begin
      if (pop && is_write && in_range) begin
         palette_mem[head_entry.addr[AW-1:0]] <= head_entry.color;
      end
      if (pop && !is_write) begin
         rd_data_ff   <= palette_mem[head_entry.addr[AW-1:0]];
         s1_hit_ff    <= (head_entry.op == rps_pkg::OP_PIXEL) && in_range;
         s1_alpha_ff  <= head_entry.alpha;
         s1_repeat_ff <= head_entry.repeat_cnt;
      end
   end

   always_comb begin
      if (pop) begin
         s1_valid_in = !is_write;
      end else begin
         s1_valid_in = s1_valid_ff && !out_free;
      end
   end

   // Unlit or transparent pixels read as colour zero
   assign color = s1_hit_ff ? rd_data_ff : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         red_ff    <= {color[15:11], 3'b000};
         green_ff  <= {color[10:5], 2'b00};
         blue_ff   <= {color[4:0], 3'b000};
         alpha_ff  <= s1_alpha_ff;
         repeat_ff <= s1_repeat_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_alpha      = alpha_ff;
   assign rsp_repeat_res = repeat_ff;

`ifndef ASSERT_OFF
   a_write_no_pixel: assert property (@(posedge clock) disable iff (reset)
      (pop && is_write) |=> !s1_valid_ff)
      else $error("palette write produced a pixel");
   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("lookup stage dropped a pixel under stall");
`endif

endmodule

### src/rle_palette_sprite_decoder.sv
// Run-length palette sprite decoder: one request beat per cycle when not stalled.
// A pixel reaches rsp through the queue slot, the palette read register and the output register.
// Throughput is set by the single palette port: one lookup or write per cycle while rsp is not stalled.
// The four-entry queue absorbs rsp stalls; req_stall rises only when it is full.
// Synchronous active-high reset clears parse state, codes and queue; palette is kept
// undefined until written.
module rle_palette_sprite_decoder #(
   parameter int PALETTE_ENTRIES = rps_pkg::PALETTE_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_palette_slot,
   input  logic [15:0] req_palette_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_res
);

   logic                 accept, push, full, head_valid, pop;
   rps_pkg::q_entry_type push_entry, head_entry;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   rps_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .accept        (accept),
      .cmd           (req_cmd),
      .data_byte     (req_data_byte),
      .palette_slot  (req_palette_slot),
      .palette_color (req_palette_color),
      .push          (push),
      .push_entry    (push_entry)
   );

   rps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   rps_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_repeat_res (rsp_repeat_res)
   );

endmodule

### bench/rle_palette_sprite_decoder_test.sv
// Self-checking testbench for rle_palette_sprite_decoder: directed and random sprite
// streams, palette writes and restarts under random idling, checked pixel by pixel.
// Depends on rps_pkg and the decoder RTL only.
module rle_palette_sprite_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         DRAIN_CYCLES = 16;
   localparam int         IDLE_LIMIT   = 2000;

   typedef struct {
      logic [1:0]  cmd;
      logic [7:0]  data_byte;
      logic [7:0]  palette_slot;
      logic [15:0] palette_color;
   } request_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] repeat_res;
   } pixel_type;

   // Tracks the decoder's parse state and palette, queues the pixels it should emit
   class pixel_scoreboard;
      logic [7:0]              transparent_code;
      logic [7:0]              semi_code;
      rps_pkg::parse_mode_type mode;
      logic [7:0]              run_left;
      logic [15:0]             palette [rps_pkg::PALETTE_ENTRIES];
      pixel_type               expected_pixels [$];
      int                      failures;

      function new();
         transparent_code = rps_pkg::TRANSPARENT_RESET;
         semi_code        = rps_pkg::SEMI_RESET;
         mode             = rps_pkg::MODE_CODE;
         run_left         = '0;
         failures         = 0;
         foreach (palette[i]) palette[i] = '0;
      endfunction

      function void set_register(logic index, logic [7:0] value);
         if (index == rps_pkg::CSR_TRANSPARENT) transparent_code = value;
         else semi_code = value;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      function void note_request(request_type r);
         pixel_type   px;
         logic [15:0] color;
         px = '{default: '0};
         case (r.cmd)
            rps_pkg::CMD_PAL_WR: begin
               if (r.palette_slot < rps_pkg::PALETTE_ENTRIES)
                  palette[r.palette_slot] = r.palette_color;
            end
            rps_pkg::CMD_RESTART: begin
               mode     = rps_pkg::MODE_CODE;
               run_left = '0;
            end
            rps_pkg::CMD_STREAM: begin
               case (mode)
                  rps_pkg::MODE_TCOUNT: begin
                     mode = rps_pkg::MODE_CODE;
                     if (r.data_byte != 8'd0) begin
                        px.alpha        = rps_pkg::ALPHA_CLEAR;
                        px.repeat_res   = r.data_byte;
                        expected_pixels = {expected_pixels, px};
                     end
                  end
                  rps_pkg::MODE_SCOUNT: begin
                     run_left = r.data_byte;
                     if (r.data_byte == 8'd0) mode = rps_pkg::MODE_CODE;
                     else mode = rps_pkg::MODE_SIDX;
                  end
                  rps_pkg::MODE_SIDX, rps_pkg::MODE_OIDX: begin
                     color = '0;
                     if (r.data_byte < rps_pkg::PALETTE_ENTRIES) color = palette[r.data_byte];
                     px.red          = {color[15:11], 3'b000};
                     px.green        = {color[10:5], 2'b00};
                     px.blue         = {color[4:0], 3'b000};
                     px.alpha        = (mode == rps_pkg::MODE_SIDX) ?
                                       rps_pkg::ALPHA_SEMI : rps_pkg::ALPHA_OPAQUE;
                     px.repeat_res   = 8'd1;
                     expected_pixels = {expected_pixels, px};
                     run_left = run_left - 8'd1;
                     if (run_left == 8'd0) mode = rps_pkg::MODE_CODE;
                  end
                  default: begin
                     // transparent code wins when both codes are equal
                     if (r.data_byte == transparent_code) begin
                        mode = rps_pkg::MODE_TCOUNT;
                     end else if (r.data_byte == semi_code) begin
                        mode = rps_pkg::MODE_SCOUNT;
                     end else begin
                        run_left = r.data_byte;
                        if (r.data_byte == 8'd0) mode = rps_pkg::MODE_CODE;
                        else mode = rps_pkg::MODE_OIDX;
                     end
                  end
               endcase
            end
            default: ;
         endcase
      endfunction

      function void check_pixel(pixel_type got);
         pixel_type exp;
         if (expected_pixels.size() == 0) begin
            $error("pixel beat with nothing expected");
            failures++;
            return;
         end
         exp = expected_pixels.pop_front();
         if (got.red !== exp.red) begin
            $error("red expected %0d got %0d", exp.red, got.red);
            failures++;
         end
         if (got.green !== exp.green) begin
            $error("green expected %0d got %0d", exp.green, got.green);
            failures++;
         end
         if (got.blue !== exp.blue) begin
            $error("blue expected %0d got %0d", exp.blue, got.blue);
            failures++;
         end
         if (got.alpha !== exp.alpha) begin
            $error("alpha expected %0d got %0d", exp.alpha, got.alpha);
            failures++;
         end
         if (got.repeat_res !== exp.repeat_res) begin
            $error("repeat_res expected %0d got %0d", exp.repeat_res, got.repeat_res);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [7:0]  req_data_byte;
   logic [7:0]  req_palette_slot;
   logic [15:0] req_palette_color;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_res;

   pixel_scoreboard sb = new();
   int              pixels_seen = 0;
   int              burst_left  = 0;
   bit              slot_written [256];
   logic [7:0]      written_slots [$];

   rle_palette_sprite_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_palette_slot  (req_palette_slot),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_red           (rsp_red),
      .rsp_green         (rsp_green),
      .rsp_blue          (rsp_blue),
      .rsp_alpha         (rsp_alpha),
      .rsp_repeat_res    (rsp_repeat_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic request_type make_req(logic [1:0] cmd, logic [7:0] data_byte,
                                            logic [7:0] slot, logic [15:0] color);
      request_type r;
      r.cmd           = cmd;
      r.data_byte     = data_byte;
      r.palette_slot  = slot;
      r.palette_color = color;
      return r;
   endfunction

   // Offer one beat after a random gap and hold it until taken
   task automatic send_request(input request_type r);
      int gap;
      int roll;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 5) burst_left = $urandom_range(20, 60);
         else if (roll < 55) gap = 0;
         else if (roll < 85) gap = $urandom_range(1, 3);
         else if (roll < 97) gap = $urandom_range(4, 8);
         else gap = $urandom_range(15, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_cmd           <= r.cmd;
      req_data_byte     <= r.data_byte;
      req_palette_slot  <= r.palette_slot;
      req_palette_color <= r.palette_color;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      if (r.cmd == rps_pkg::CMD_PAL_WR && !slot_written[r.palette_slot]) begin
         slot_written[r.palette_slot] = 1'b1;
         written_slots = {written_slots, r.palette_slot};
      end
   endtask

   // Leaves csr_valid high; the caller drops it after its last write
   task automatic write_register(input logic index, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, value);
   endtask

   // Wait for every pixel, then let queued palette writes settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] tcode, input logic [7:0] scode, input int count);
      request_type r;
      int          roll;
      write_register(rps_pkg::CSR_TRANSPARENT, tcode);
      write_register(rps_pkg::CSR_SEMI, scode);
      csr_valid <= 1'b0;
      repeat (count) begin
         r.cmd           = rps_pkg::CMD_STREAM;
         r.data_byte     = 8'($urandom);
         r.palette_slot  = 8'($urandom);
         r.palette_color = 16'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            // noise: breaks runs or slips a palette write into them
            roll = $urandom_range(0, 99);
            if (roll < 55) r.cmd = rps_pkg::CMD_PAL_WR;
            else if (roll < 80) r.cmd = rps_pkg::CMD_RESTART;
            else r.cmd = CMD_UNUSED;
         end else begin
            roll = $urandom_range(0, 99);
            case (sb.mode)
               rps_pkg::MODE_CODE: begin
                  if (roll < 22) r.data_byte = sb.transparent_code;
                  else if (roll < 44) r.data_byte = sb.semi_code;
                  else if (roll < 50) r.data_byte = 8'd0;
                  else if (roll < 98) r.data_byte = 8'($urandom_range(1, 6));
               end
               rps_pkg::MODE_TCOUNT: begin
                  if (roll < 10) r.data_byte = 8'd0;
               end
               rps_pkg::MODE_SCOUNT: begin
                  if (roll < 10) r.data_byte = 8'd0;
                  else if (roll < 95) r.data_byte = 8'($urandom_range(1, 6));
               end
               default: begin
                  // only ever index entries that hold a written colour
                  r.data_byte = written_slots[$urandom_range(0, written_slots.size() - 1)];
               end
            endcase
         end
         send_request(r);
      end
      drain();
   endtask

   // Result side: check every pixel beat, stall in random stretches
   initial begin : pixel_sink
      int stall_left;
      int free_left;
      int pressure_left;
      bit pressure_done;
      stall_left    = 0;
      free_left     = 0;
      pressure_left = 0;
      pressure_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_pixel('{rsp_red, rsp_green, rsp_blue, rsp_alpha, rsp_repeat_res});
            pixels_seen++;
         end
         if (!pressure_done && pixels_seen >= 40) begin
            // long hold-off so the queue fills and the request side backs up
            pressure_left = 120;
            pressure_done = 1'b1;
         end
         if (pressure_left > 0) begin
            pressure_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_stall <= 1'b0;
         end else begin
            free_left = $urandom_range(0, 24);
            case ($urandom_range(0, 9))
               0, 1, 2:    stall_left = 0;
               3, 4, 5, 6: stall_left = $urandom_range(1, 3);
               7, 8:       stall_left = $urandom_range(4, 10);
               default:    stall_left = $urandom_range(20, 40);
            endcase
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("rle_palette_sprite_decoder_test failed");
            $finish;
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      csr_valid         <= 1'b0;
      csr_index         <= rps_pkg::CSR_TRANSPARENT;
      csr_data          <= '0;
      req_valid         <= 1'b0;
      req_cmd           <= rps_pkg::CMD_STREAM;
      req_data_byte     <= '0;
      req_palette_slot  <= '0;
      req_palette_color <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset codes: transparent 0, semi 1
      send_request(make_req(rps_pkg::CMD_PAL_WR, 8'h00, 8'h00, 16'hFFFF));
      send_request(make_req(rps_pkg::CMD_PAL_WR, 8'hFF, 8'hFF, 16'hF800));
      send_request(make_req(rps_pkg::CMD_PAL_WR, 8'h00, 8'hAA, 16'h07E0));
      send_request(make_req(rps_pkg::CMD_PAL_WR, 8'h00, 8'h55, 16'h001F));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd0, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd255, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd0, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd1, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd0, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd0, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd1, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd2, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'h00, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'hFF, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd1, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd0, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd3, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'hAA, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_PAL_WR, 8'h00, 8'h10, 16'h1234));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'h55, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'h10, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'd2, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_STREAM, 8'h00, 8'h00, 16'h0000));
      send_request(make_req(rps_pkg::CMD_RESTART, 8'hFF, 8'hFF, 16'hFFFF));
      send_request(make_req(CMD_UNUSED, 8'hFF, 8'hFF, 16'hFFFF));
      drain();

      run_phase(8'd0, 8'd1, 170);
      run_phase(8'd255, 8'd0, 170);
      run_phase(8'd7, 8'd7, 170);
      run_phase(8'd255, 8'd255, 170);
      run_phase(8'd0, 8'd255, 170);
      run_phase(8'($urandom), 8'($urandom), 170);
      run_phase(8'($urandom), 8'($urandom), 170);

      if (sb.failures == 0 && sb.pending() == 0)
         $display("rle_palette_sprite_decoder_test passed");
      else
         $display("rle_palette_sprite_decoder_test failed");
      $finish;
   end

endmodule
